FILE: hw/rtl/rdte_pkg.sv
// Shared types, constants and helper functions of the RTC date to epoch seconds unit.
package rdte_pkg;

    localparam int unsigned NUM_STAGES = 7;

    localparam int unsigned YEAR_W = 12;
    localparam int unsigned BYTE_W = 8;

    localparam logic [YEAR_W-1:0] CENTURY_BASE = 12'd1900;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 12'd1970;
    localparam logic [YEAR_W-1:0] CENTURY_LEN  = 12'd100;

    localparam logic [31:0] DAY_OFFSET    = 32'd719499;
    localparam logic [16:0] MONTH_NUM     = 17'd367;
    localparam logic [20:0] DAYS_PER_YEAR = 21'd365;

    // Reciprocal constants for division by 100 and by 3 on narrow values.
    localparam logic [24:0] DIV100_MUL   = 25'd5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam logic [29:0] DIV3_MUL     = 30'd43691;
    localparam int unsigned DIV3_SHIFT   = 17;

    typedef enum logic
    {
        REG_BINARY_FORMAT = 1'b0,
        REG_FORCE_BCD     = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [YEAR_W-1:0] year;
        logic [BYTE_W-1:0] month_f;
        logic [BYTE_W-1:0] day;
        logic [BYTE_W-1:0] hour;
        logic [BYTE_W-1:0] minute;
        logic [BYTE_W-1:0] second;
    } front_t;

    typedef struct packed
    {
        logic binary_format;
        logic force_bcd;
    } mode_t;

    function automatic logic [BYTE_W-1:0] bcd_dec(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] tens;
        tens = 8'({4'd0, b[7:4]} * 8'd10);
        return tens + {4'd0, b[3:0]};
    endfunction

endpackage

FILE: hw/rtl/rdte_front.sv
// Front stage logic: optional BCD decoding, century fix-up and month fold.
module rdte_front
(
    input  rdte_pkg::mode_t   mode,
    input  logic [7:0]        seconds_raw,
    input  logic [7:0]        minutes_raw,
    input  logic [7:0]        hours_raw,
    input  logic [7:0]        day_raw,
    input  logic [7:0]        month_raw,
    input  logic [7:0]        year_raw,
    output rdte_pkg::front_t  front
);

    logic                            use_bcd;
    logic [rdte_pkg::BYTE_W-1:0]     sec_d;
    logic [rdte_pkg::BYTE_W-1:0]     min_d;
    logic [rdte_pkg::BYTE_W-1:0]     hour_d;
    logic [rdte_pkg::BYTE_W-1:0]     day_d;
    logic [rdte_pkg::BYTE_W-1:0]     mon_d;
    logic [rdte_pkg::BYTE_W-1:0]     year_d;
    logic [rdte_pkg::YEAR_W-1:0]     year_full;
    logic [rdte_pkg::YEAR_W-1:0]     year_fix;

    assign use_bcd = !mode.binary_format || mode.force_bcd;

    always_comb
    begin
        if (use_bcd)
        begin
            sec_d  = rdte_pkg::bcd_dec(seconds_raw);
            min_d  = rdte_pkg::bcd_dec(minutes_raw);
            hour_d = rdte_pkg::bcd_dec(hours_raw);
            day_d  = rdte_pkg::bcd_dec(day_raw);
            mon_d  = rdte_pkg::bcd_dec(month_raw);
            year_d = rdte_pkg::bcd_dec(year_raw);
        end
        else
        begin
            sec_d  = seconds_raw;
            min_d  = minutes_raw;
            hour_d = hours_raw;
            day_d  = day_raw;
            mon_d  = month_raw;
            year_d = year_raw;
        end
    end

    always_comb
    begin
        year_full = {4'd0, year_d} + rdte_pkg::CENTURY_BASE;
        if (year_full < rdte_pkg::EPOCH_YEAR)
        begin
            year_fix = year_full + rdte_pkg::CENTURY_LEN;
        end
        else
        begin
            year_fix = year_full;
        end

        front.day    = day_d;
        front.hour   = hour_d;
        front.minute = min_d;
        front.second = sec_d;

        // January and February count as months eleven and twelve of the previous year.
        if (mon_d <= 8'd2)
        begin
            front.month_f = mon_d + 8'd10;
            front.year    = year_fix - 12'd1;
        end
        else
        begin
            front.month_f = mon_d - 8'd2;
            front.year    = year_fix;
        end
    end

endmodule

FILE: hw/rtl/rtc_date_to_epoch_seconds_unit.sv
// Top level of the RTC date to epoch seconds unit: config registers and the arithmetic pipeline.
//
//   channel   direction  handshake                  word
//   in        input      in_valid / in_ready        six raw RTC bytes
//   out       output     out_valid / out_ready      epoch_seconds
//   cfg       input      cfg_we                     cfg_addr, cfg_wdata
//
// The unit is a seven-stage pipeline that takes one word per cycle while the output is not stalled.
// An accepted word is registered in s1_reg first and leaves through out_reg, the last stage.
// Reset clears all valid bits and both mode registers.
// A stalled stage holds its word, and empty stages before it keep filling.
module rtc_date_to_epoch_seconds_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic        cfg_wdata,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  seconds_raw,
    input  logic [7:0]  minutes_raw,
    input  logic [7:0]  hours_raw,
    input  logic [7:0]  day_raw,
    input  logic [7:0]  month_raw,
    input  logic [7:0]  year_raw,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] epoch_seconds
);

    localparam int unsigned NS = rdte_pkg::NUM_STAGES;

    rdte_pkg::mode_t   mode_reg;
    rdte_pkg::front_t  front;

    logic [NS-1:0]     vld_reg;
    logic [NS-1:0]     vld_next;
    logic [NS-1:0]     rdy;

    // Stage one.
    rdte_pkg::front_t  s1_reg;
    // Stage two.
    logic [24:0]       p100_reg;
    logic [16:0]       mterm_reg;
    logic [20:0]       y365_reg;
    logic [11:0]       year2_reg;
    logic [7:0]        day2_reg;
    logic [7:0]        hour2_reg;
    logic [7:0]        min2_reg;
    logic [7:0]        sec2_reg;
    // Stage three.
    logic [29:0]       p3_reg;
    logic [21:0]       sum3_reg;
    logic [7:0]        hour3_reg;
    logic [7:0]        min3_reg;
    logic [7:0]        sec3_reg;
    // Stage four.
    logic [31:0]       days_reg;
    logic [7:0]        hour4_reg;
    logic [7:0]        min4_reg;
    logic [7:0]        sec4_reg;
    // Stage five.
    logic [31:0]       hrs_reg;
    logic [7:0]        min5_reg;
    logic [7:0]        sec5_reg;
    // Stage six.
    logic [31:0]       mins_reg;
    logic [7:0]        sec6_reg;
    // Stage seven.
    logic [31:0]       out_reg;

    logic [5:0]        q100;
    logic [3:0]        q400;
    logic [9:0]        y4;
    logic [14:0]       mq4;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (rdte_pkg::reg_index_t'(cfg_addr))
                rdte_pkg::REG_BINARY_FORMAT: mode_reg.binary_format <= cfg_wdata;
                rdte_pkg::REG_FORCE_BCD:     mode_reg.force_bcd     <= cfg_wdata;
                default:                     mode_reg               <= mode_reg;
            endcase
        end
    end

    rdte_front u_front
    (
        .mode        (mode_reg),
        .seconds_raw (seconds_raw),
        .minutes_raw (minutes_raw),
        .hours_raw   (hours_raw),
        .day_raw     (day_raw),
        .month_raw   (month_raw),
        .year_raw    (year_raw),
        .front       (front)
    );

    // A stage takes a new word when it is empty or its word moves on.
    always_comb
    begin
        rdy[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < NS; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign q100 = p100_reg[24:rdte_pkg::DIV100_SHIFT];
    assign q400 = q100[5:2];
    assign y4   = year2_reg[11:2];
    assign mq4  = mterm_reg[16:2];

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_reg <= front;
        end
        if (rdy[1])
        begin
            p100_reg  <= 25'(s1_reg.year) * rdte_pkg::DIV100_MUL;
            mterm_reg <= 17'(s1_reg.month_f) * rdte_pkg::MONTH_NUM;
            y365_reg  <= 21'(s1_reg.year) * rdte_pkg::DAYS_PER_YEAR;
            year2_reg <= s1_reg.year;
            day2_reg  <= s1_reg.day;
            hour2_reg <= s1_reg.hour;
            min2_reg  <= s1_reg.minute;
            sec2_reg  <= s1_reg.second;
        end
        if (rdy[2])
        begin
            // Dividing 367 * month by 12 is a shift by two and a division by three.
            p3_reg    <= 30'(mq4) * rdte_pkg::DIV3_MUL;
            sum3_reg  <= 22'(y365_reg) + 22'(y4) - 22'(q100) + 22'(q400) + 22'(day2_reg);
            hour3_reg <= hour2_reg;
            min3_reg  <= min2_reg;
            sec3_reg  <= sec2_reg;
        end
        if (rdy[3])
        begin
            days_reg  <= 32'(sum3_reg) + 32'(p3_reg[29:rdte_pkg::DIV3_SHIFT])
                         - rdte_pkg::DAY_OFFSET;
            hour4_reg <= hour3_reg;
            min4_reg  <= min3_reg;
            sec4_reg  <= sec3_reg;
        end
        if (rdy[4])
        begin
            hrs_reg  <= days_reg * 32'd24 + 32'(hour4_reg);
            min5_reg <= min4_reg;
            sec5_reg <= sec4_reg;
        end
        if (rdy[5])
        begin
            mins_reg <= hrs_reg * 32'd60 + 32'(min5_reg);
            sec6_reg <= sec5_reg;
        end
        if (rdy[6])
        begin
            out_reg <= mins_reg * 32'd60 + 32'(sec6_reg);
        end
    end

    assign in_ready      = rdy[0];
    assign out_valid     = vld_reg[NS-1];
    assign epoch_seconds = out_reg;

    // An empty output stage never holds back the input.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready although the output stage is empty");

    // An accepted word lands in the first stage.
    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted word missing from the first stage");

    // A stalled day count is neither dropped nor altered.
    a_days_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && !rdy[4] |=> vld_reg[3] && $stable(days_reg))
        else $error("stalled day count changed or lost");

endmodule

FILE: tb/rtc_date_to_epoch_seconds_checker.sv
// Checker that predicts the epoch seconds of every accepted word and compares each result.
module rtc_date_to_epoch_seconds_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic        cfg_wdata,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  seconds_raw,
    input  logic [7:0]  minutes_raw,
    input  logic [7:0]  hours_raw,
    input  logic [7:0]  day_raw,
    input  logic [7:0]  month_raw,
    input  logic [7:0]  year_raw,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] epoch_seconds,

    output int unsigned fail_count,
    output int unsigned words_due,
    output int unsigned words_checked
);

    logic        binary_mode = 1'b0;
    logic        bcd_forced  = 1'b0;
    logic [31:0] epochs_due[$];

    function automatic logic [31:0] bcd_byte_value(input logic [7:0] b);
        return 32'(b[3:0]) + 32'(b[7:4]) * 32'd10;
    endfunction

    function automatic logic [31:0] epoch_of
    (
        input logic [7:0] s_b, m_b, h_b, d_b, mo_b, y_b,
        input logic       decode
    );
        logic [31:0] secs, mins, hrs, mday, mon, yr, fold, days;
        secs = decode ? bcd_byte_value(s_b)  : 32'(s_b);
        mins = decode ? bcd_byte_value(m_b)  : 32'(m_b);
        hrs  = decode ? bcd_byte_value(h_b)  : 32'(h_b);
        mday = decode ? bcd_byte_value(d_b)  : 32'(d_b);
        mon  = decode ? bcd_byte_value(mo_b) : 32'(mo_b);
        yr   = decode ? bcd_byte_value(y_b)  : 32'(y_b);
        yr = yr + 32'd1900;
        if (yr < 32'd1970)
            yr = yr + 32'd100;
        // March is the first month of the folded year; a non-positive fold borrows a year.
        fold = mon - 32'd2;
        if (fold == 32'd0 || fold[31])
        begin
            fold = fold + 32'd12;
            yr   = yr - 32'd1;
        end
        days = yr / 32'd4 - yr / 32'd100 + yr / 32'd400 + (32'd367 * fold) / 32'd12 + mday;
        days = days + yr * 32'd365 - 32'd719499;
        return ((days * 32'd24 + hrs) * 32'd60 + mins) * 32'd60 + secs;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [31:0] expected;
        if (!rst_n)
        begin
            epochs_due.delete();
            binary_mode <= 1'b0;
            bcd_forced  <= 1'b0;
            words_due   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (epochs_due.size() == 0)
                begin
                    $error("epoch_seconds: word %0d arrived with none expected", epoch_seconds);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    expected = epochs_due.pop_front();
                    if (epoch_seconds !== expected)
                    begin
                        $error("epoch_seconds mismatch: expected %0d, actual %0d",
                               expected, epoch_seconds);
                        fail_count <= fail_count + 1;
                    end
                end
                words_checked <= words_checked + 1;
            end
            if (in_valid && in_ready)
                epochs_due.push_back(epoch_of(seconds_raw, minutes_raw, hours_raw, day_raw,
                                              month_raw, year_raw,
                                              !binary_mode || bcd_forced));
            if (cfg_we)
            begin
                if (cfg_addr == rdte_pkg::REG_BINARY_FORMAT)
                    binary_mode <= cfg_wdata;
                if (cfg_addr == rdte_pkg::REG_FORCE_BCD)
                    bcd_forced <= cfg_wdata;
            end
            words_due <= epochs_due.size();
        end
    end

endmodule

FILE: tb/rtc_date_to_epoch_seconds_unit_test.sv
// Testbench top: stimulus, output stalls and verdict for the RTC date to epoch seconds unit.
module rtc_date_to_epoch_seconds_unit_test;

    localparam int unsigned CYCLE_LIMIT = 300000;

    typedef struct packed
    {
        logic [7:0] sec;
        logic [7:0] mins;
        logic [7:0] hrs;
        logic [7:0] mday;
        logic [7:0] mon;
        logic [7:0] yr;
    } rtc_word_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_addr    = rdte_pkg::REG_BINARY_FORMAT;
    logic        cfg_wdata   = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  seconds_raw = 8'd0;
    logic [7:0]  minutes_raw = 8'd0;
    logic [7:0]  hours_raw   = 8'd0;
    logic [7:0]  day_raw     = 8'd0;
    logic [7:0]  month_raw   = 8'd0;
    logic [7:0]  year_raw    = 8'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] epoch_seconds;

    int unsigned fail_count;
    int unsigned words_due;
    int unsigned words_checked;

    int unsigned cycle_count    = 0;
    int unsigned words_sent     = 0;
    int unsigned gap_pct        = 0;
    int unsigned stall_pct      = 0;
    logic        calm           = 1'b0;
    logic        long_hold_req  = 1'b0;
    logic        long_hold_done = 1'b0;
    logic        decode_bcd     = 1'b1;

    rtc_date_to_epoch_seconds_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .seconds_raw   (seconds_raw),
        .minutes_raw   (minutes_raw),
        .hours_raw     (hours_raw),
        .day_raw       (day_raw),
        .month_raw     (month_raw),
        .year_raw      (year_raw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .epoch_seconds (epoch_seconds)
    );

    rtc_date_to_epoch_seconds_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .seconds_raw   (seconds_raw),
        .minutes_raw   (minutes_raw),
        .hours_raw     (hours_raw),
        .day_raw       (day_raw),
        .month_raw     (month_raw),
        .year_raw      (year_raw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .epoch_seconds (epoch_seconds),
        .fail_count    (fail_count),
        .words_due     (words_due),
        .words_checked (words_checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] encode_field(input int unsigned v, input logic as_bcd);
        return as_bcd ? {4'(v / 10), 4'(v % 10)} : 8'(v);
    endfunction

    function automatic rtc_word_t make_date(input logic as_bcd);
        rtc_word_t w;
        w.sec  = encode_field($urandom_range(0, 59), as_bcd);
        w.mins = encode_field($urandom_range(0, 59), as_bcd);
        w.hrs  = encode_field($urandom_range(0, 23), as_bcd);
        w.mday = encode_field($urandom_range(1, 31), as_bcd);
        w.mon  = encode_field($urandom_range(1, 12), as_bcd);
        w.yr   = encode_field($urandom_range(0, 99), as_bcd);
        return w;
    endfunction

    task automatic send_word(input rtc_word_t w);
        in_valid    <= 1'b1;
        seconds_raw <= w.sec;
        minutes_raw <= w.mins;
        hours_raw   <= w.hrs;
        day_raw     <= w.mday;
        month_raw   <= w.mon;
        year_raw    <= w.yr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    task automatic load_mode(input logic binary, input logic forced);
        cfg_we    <= 1'b1;
        cfg_addr  <= rdte_pkg::REG_BINARY_FORMAT;
        cfg_wdata <= binary;
        @(posedge clk);
        cfg_addr  <= rdte_pkg::REG_FORCE_BCD;
        cfg_wdata <= forced;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        decode_bcd = !binary || forced;
    endtask

    // Mostly well-formed dates, some with one corrupted byte, the rest pure noise.
    task automatic random_words(input int count, input int hold_at);
        rtc_word_t w;
        int        pick;
        int        k;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                w = 48'({$urandom(), $urandom()});
            else
            begin
                w = make_date(decode_bcd);
                if (pick < 30)
                begin
                    k = $urandom_range(0, 5);
                    w[8*k +: 8] = 8'($urandom());
                end
            end
            if (i == hold_at)
                long_hold_req <= 1'b1;
            send_word(w);
        end
    endtask

    initial
    begin
        wait (rst_n);
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                out_ready      <= 1'b0;
                long_hold_done <= 1'b1;
                repeat (80) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   <= 30;
        stall_pct <= 30;
        load_mode(1'b0, 1'b0);
        send_word({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70});
        send_word({8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99});
        send_word({8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h00});
        send_word({8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00});
        send_word({8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38});
        send_word({8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69});
        send_word({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_word({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_word({8'hAA, 8'h5F, 8'hF0, 8'h0A, 8'h1A, 8'h9A});
        send_word({8'h30, 8'h30, 8'h92, 8'h15, 8'h06, 8'h24});
        send_word({8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h70});
        send_word({8'h45, 8'h30, 8'h12, 8'h15, 8'h10, 8'h05});
        random_words(160, -1);
        settle();

        gap_pct   <= 15;
        stall_pct <= 40;
        load_mode(1'b1, 1'b0);
        send_word({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h46});
        send_word({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_word({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_word({8'h3B, 8'h3B, 8'h17, 8'h1F, 8'h0C, 8'h45});
        send_word({8'h00, 8'h00, 8'h00, 8'h1D, 8'h02, 8'h64});
        send_word({8'h01, 8'h02, 8'h03, 8'h04, 8'h0D, 8'h63});
        send_word({8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80});
        send_word({8'h3B, 8'h3B, 8'h17, 8'h1C, 8'h02, 8'h45});
        random_words(170, 40);
        settle();

        gap_pct   <= 50;
        stall_pct <= 10;
        load_mode(1'b1, 1'b1);
        send_word({8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99});
        send_word({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        random_words(110, -1);
        settle();

        gap_pct   <= 20;
        stall_pct <= 20;
        load_mode(1'b0, 1'b1);
        random_words(90, -1);
        settle();

        calm <= 1'b1;
        load_mode(1'b0, 1'b0);
        random_words(100, -1);
        settle();
        repeat (20) @(posedge clk);

        $display("Converted %0d words and checked %0d results across BCD, binary and forced BCD",
                 words_sent, words_checked);
        $display("modes, with invalid nibbles, month zero, year window edges and a long stall.");
        if (fail_count == 0 && words_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
